// File: hw/rtl/tbf_pkg.sv
// ----------------------------------------------------------------------------
// tbf_pkg: shared types and constants for the tape block framer
// Field widths, tape frame constants, register codes, queue entry and
// sequencer phase types.
// ----------------------------------------------------------------------------
`default_nettype none

package tbf_pkg;

  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int POS_W    = 16;
  localparam int NAME_LEN = 25;
  localparam int NAME_W   = NAME_LEN * BYTE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [BYTE_W-1:0]  SYNC_BYTE  = 8'hE6;
  localparam logic [BYTE_W-1:0]  FILL_BYTE  = 8'h55;
  localparam logic [BYTE_W-1:0]  NUM_BASE   = 8'h80;
  localparam logic [BYTE_W-1:0]  ZERO_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0]  SPACE_CHAR = 8'h20;
  localparam logic [POS_W-1:0]   MAX_LENGTH = 16'hFF00;
  localparam logic [COUNT_W-1:0] PRE_RUN    = 5'd25;

  localparam logic [NAME_W-1:0] NAME_RESET = {NAME_LEN{SPACE_CHAR}};
  localparam logic [BYTE_W-1:0] LOAD_RESET = 8'h01;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOAD_ADDR_HIGH = 3'd0,
    REG_PROGRAM_LENGTH = 3'd1,
    REG_NAME_FIRST     = 3'd2,
    REG_NAME_SECOND    = 3'd3,
    REG_NAME_THIRD     = 3'd4,
    REG_NAME_FINAL     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] load_high;
    logic [POS_W-1:0]  program_length;
    logic [NAME_W-1:0] name_chars;     // char k at bits 8k upward
  } tbf_cfg_t;

  // One accepted item, classified: which frame parts it opens or closes.
  typedef struct packed {
    logic              pre;       // preamble first
    logic              name;      // name block before the data
    logic              chunk;     // data block header before the data
    logic              data;      // data byte run (clear for empty program)
    logic              trail;     // data block sum after the data
    logic              tape_end;  // last run of this entry ends the tape
    logic [2:0]        chunk_num;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] blocks;
    logic [BYTE_W-1:0] remain;
  } tbf_entry_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_LEAD,
    PH_CHARS,
    PH_TAIL,
    PH_CHUNK,
    PH_DATA,
    PH_TRAIL
  } tbf_phase_t;

endpackage

`default_nettype wire

// File: hw/rtl/tbf_if.sv
// ----------------------------------------------------------------------------
// tbf_if: item channels of the tape block framer
// Input channel carries program bytes, output channel carries tape runs.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbf_in_if import tbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tbf_out_if import tbf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  byte_value;
  logic [COUNT_W-1:0] repeat_count;
  logic               last_of_item;
  logic               end_of_tape;

  modport source (output valid, output byte_value, output repeat_count,
                  output last_of_item, output end_of_tape, input ready);
  modport sink   (input valid, input byte_value, input repeat_count,
                  input last_of_item, input end_of_tape, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tbf_front.sv
// ----------------------------------------------------------------------------
// tbf_front: item intake and classification
// Tracks the byte position and turns each item into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tbf_front import tbf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  tbf_in_if.sink          in,
  input  wire tbf_cfg_t   cfg,
  input  wire logic       queue_full,
  output tbf_entry_t      entry,
  output logic            push
);

  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [POS_W-1:0]  len;
  logic [BYTE_W-1:0] blocks;
  logic [POS_W-1:0]  total;
  logic              empty_prog;
  logic              skip;
  logic              accept;

  assign in.ready = !queue_full;
  assign accept   = in.valid && in.ready;

  always_comb begin
    len        = (cfg.program_length > MAX_LENGTH) ? MAX_LENGTH : cfg.program_length;
    blocks     = len[15:8] + BYTE_W'(|len[7:0]);
    total      = {blocks, 8'h00};
    empty_prog = (blocks == '0);
    // past the end of the tape: swallowed, nothing emitted
    skip       = (pos >= total) && !((pos == '0) && empty_prog);

    entry.pre       = (pos == '0);
    entry.name      = !empty_prog && (pos[7:0] == 8'h00);
    entry.chunk     = !empty_prog && (pos[4:0] == 5'd0);
    entry.data      = !empty_prog;
    entry.trail     = !empty_prog && (pos[4:0] == 5'd31);
    entry.tape_end  = empty_prog || (entry.trail && (pos == total - 16'd1));
    entry.chunk_num = pos[7:5];
    entry.value     = (pos < len) ? in.data_byte : ZERO_BYTE;
    entry.blocks    = blocks;
    entry.remain    = blocks - pos[15:8];

    push     = accept && !skip;
    pos_next = pos;
    if (push) begin
      pos_next = empty_prog ? POS_W'(1) : pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tbf_queue.sv
// ----------------------------------------------------------------------------
// tbf_queue: entry queue between front and back
// Small register FIFO with a visible head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tbf_queue import tbf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire tbf_entry_t wr_entry,
  input  wire logic       pop,
  output tbf_entry_t      head,
  output logic            head_valid,
  output logic            full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tbf_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head       = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tbf_back.sv
// ----------------------------------------------------------------------------
// tbf_back: run sequencer
// Expands the head entry into tape runs, one per cycle unless stalled,
// keeps the header and data block sums, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbf_back import tbf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire tbf_cfg_t   cfg,
  input  wire tbf_entry_t head,
  input  wire logic       head_valid,
  output logic            pop,
  tbf_out_if.source       out
);

  tbf_phase_t         phase;
  tbf_phase_t         phase_next;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] cnt_next;
  tbf_phase_t         cur_phase;
  tbf_phase_t         nph;
  logic [COUNT_W-1:0] cur_cnt;
  logic [COUNT_W-1:0] last_cnt;
  logic               phase_last;
  logic               entry_last;
  logic               fire;

  logic [BYTE_W-1:0]  run_value;
  logic [COUNT_W-1:0] run_count;
  logic [BYTE_W-1:0]  name_char;
  logic [7:0]         char_base;

  logic [BYTE_W-1:0]  hsum;
  logic [BYTE_W-1:0]  hsum_next;
  logic [BYTE_W-1:0]  dsum;
  logic [BYTE_W-1:0]  dsum_next;

  logic               out_valid;
  logic [BYTE_W-1:0]  out_value;
  logic [COUNT_W-1:0] out_count;
  logic               out_last;
  logic               out_eot;

  function automatic tbf_phase_t next_phase(input tbf_phase_t ph, input tbf_entry_t e);
    tbf_phase_t r;
    unique case (ph)
      PH_IDLE:  r = e.pre ? PH_PRE : e.name ? PH_LEAD : e.chunk ? PH_CHUNK :
                    e.data ? PH_DATA : PH_IDLE;
      PH_PRE:   r = e.name ? PH_LEAD : e.chunk ? PH_CHUNK : e.data ? PH_DATA : PH_IDLE;
      PH_LEAD:  r = PH_CHARS;
      PH_CHARS: r = PH_TAIL;
      PH_TAIL:  r = e.chunk ? PH_CHUNK : PH_DATA;
      PH_CHUNK: r = PH_DATA;
      PH_DATA:  r = e.trail ? PH_TRAIL : PH_IDLE;
      PH_TRAIL: r = PH_IDLE;
      default:  r = PH_IDLE;
    endcase
    return r;
  endfunction

  assign fire = head_valid && (!out_valid || out.ready);
  assign pop  = fire && entry_last;

  assign char_base = {cur_cnt, 3'b000};
  assign name_char = cfg.name_chars[char_base +: BYTE_W];

  always_comb begin
    cur_phase = (phase == PH_IDLE) ? next_phase(PH_IDLE, head) : phase;
    cur_cnt   = (phase == PH_IDLE) ? '0 : cnt;
    nph       = next_phase(cur_phase, head);

    run_value = ZERO_BYTE;
    run_count = COUNT_W'(1);
    last_cnt  = '0;
    hsum_next = hsum;
    dsum_next = dsum;

    unique case (cur_phase)
      PH_PRE: begin
        last_cnt  = COUNT_W'(7);
        run_value = cur_cnt[0] ? FILL_BYTE : ZERO_BYTE;
        run_count = PRE_RUN;
      end
      PH_LEAD: begin
        last_cnt  = COUNT_W'(3);
        hsum_next = '0;
        case (cur_cnt[1:0])
          2'd0:    begin run_value = ZERO_BYTE; run_count = COUNT_W'(16); end
          2'd1:    begin run_value = FILL_BYTE; run_count = COUNT_W'(4);  end
          2'd2:    begin run_value = SYNC_BYTE; run_count = COUNT_W'(1);  end
          default: begin run_value = ZERO_BYTE; run_count = COUNT_W'(4);  end
        endcase
      end
      PH_CHARS: begin
        last_cnt  = COUNT_W'(NAME_LEN - 1);
        run_value = name_char;
        hsum_next = hsum + name_char;
      end
      PH_TAIL: begin
        last_cnt = COUNT_W'(4);
        case (cur_cnt[2:0])
          3'd0:    begin run_value = ZERO_BYTE; run_count = COUNT_W'(2); end
          3'd1:    run_value = cfg.load_high;
          3'd2:    run_value = head.blocks;
          3'd3:    run_value = head.remain;
          default: run_value = hsum;
        endcase
        if (cur_cnt == COUNT_W'(1) || cur_cnt == COUNT_W'(2) || cur_cnt == COUNT_W'(3)) begin
          hsum_next = hsum + run_value;
        end
      end
      PH_CHUNK: begin
        last_cnt = COUNT_W'(3);
        case (cur_cnt[1:0])
          2'd0:    begin run_value = ZERO_BYTE; run_count = COUNT_W'(4); end
          2'd1:    run_value = SYNC_BYTE;
          2'd2:    run_value = NUM_BASE + BYTE_W'(head.chunk_num);
          default: begin
            run_value = hsum;
            dsum_next = NUM_BASE + BYTE_W'(head.chunk_num) + hsum;
          end
        endcase
      end
      PH_DATA: begin
        run_value = head.value;
        dsum_next = dsum + head.value;
      end
      PH_TRAIL: begin
        run_value = dsum;
      end
      default: begin
        run_value = ZERO_BYTE;
      end
    endcase

    phase_last = (cur_cnt == last_cnt);
    entry_last = phase_last && (nph == PH_IDLE);

    phase_next = phase;
    cnt_next   = cnt;
    if (fire) begin
      if (entry_last) begin
        phase_next = PH_IDLE;
        cnt_next   = '0;
      end else if (phase_last) begin
        phase_next = nph;
        cnt_next   = '0;
      end else begin
        phase_next = cur_phase;
        cnt_next   = cur_cnt + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      cnt       <= '0;
      hsum      <= '0;
      dsum      <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
      if (fire) begin
        hsum      <= hsum_next;
        dsum      <= dsum_next;
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_value <= run_value;
      out_count <= run_count;
      out_last  <= entry_last;
      out_eot   <= entry_last && head.tape_end;
    end
  end

  assign out.valid        = out_valid;
  assign out.byte_value   = out_value;
  assign out.repeat_count = out_count;
  assign out.last_of_item = out_last;
  assign out.end_of_tape  = out_eot;

endmodule

`default_nettype wire

// File: hw/rtl/tape_block_framer.sv
// ----------------------------------------------------------------------------
// tape_block_framer: cassette frame builder with run-length output
// Builds the preamble, name blocks and data blocks around program bytes.
// ----------------------------------------------------------------------------
// Each input item is one program byte; the block answers with the tape
// frame it causes as runs of (byte_value, repeat_count), with last_of_item
// on the final run of the item and end_of_tape on the final run of the
// whole image. The front stage tracks the byte position and classifies each
// item (preamble, name block, data block header, checksum trailer) into a
// small queue; the back stage expands the queue head one run per clock
// while the output is not stalled, into a registered output. An item yields
// one run for a plain data byte, two when it closes a 32-byte data block,
// four more when it opens one, and up to 47 for the first item of the tape.
// The front takes a new item every cycle while the queue has room, so a
// burst of plain bytes flows at one item per clock if the output does not
// stall. Items past the end of the tape are accepted and dropped without
// output. Configuration is written through cfg_we/cfg_index/cfg_data while
// the block is idle; indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_block_framer import tbf_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  tbf_in_if.sink                     in,
  tbf_out_if.source                  out,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  tbf_cfg_t   cfg;
  tbf_entry_t wr_entry;
  tbf_entry_t head;
  logic       push;
  logic       pop;
  logic       head_valid;
  logic       queue_full;

  // configuration registers; name chars held as one 25-byte vector
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.load_high      <= LOAD_RESET;
      cfg.program_length <= '0;
      cfg.name_chars     <= NAME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LOAD_ADDR_HIGH: cfg.load_high              <= cfg_data[BYTE_W-1:0];
        REG_PROGRAM_LENGTH: cfg.program_length         <= cfg_data[POS_W-1:0];
        REG_NAME_FIRST:     cfg.name_chars[63:0]    <= cfg_data;
        REG_NAME_SECOND:    cfg.name_chars[127:64]  <= cfg_data;
        REG_NAME_THIRD:     cfg.name_chars[191:128] <= cfg_data;
        REG_NAME_FINAL:     cfg.name_chars[199:192] <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // intake: position tracking and classification
  tbf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in         (in),
    .cfg        (cfg),
    .queue_full (queue_full),
    .entry      (wr_entry),
    .push       (push)
  );

  // decouples intake from run expansion
  tbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_entry   (wr_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  // run sequencer with header/data sums and output register
  tbf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out        (out)
  );

endmodule

`default_nettype wire
